>>> rtl/core/spwf_pkg.sv
// Shared types and constants of the septet packing write framer.
// Used by spwf_front, spwf_queue, spwf_back and septet_packing_write_framer.
`default_nettype none

package spwf_pkg;

	localparam int STEP_W = 5;

	// Framing bytes
	localparam logic [7:0] SOX_BYTE = 8'hf0;
	localparam logic [7:0] EOX_BYTE = 8'hf7;
	localparam logic [7:0] MFR_0    = 8'h00;
	localparam logic [7:0] MFR_1    = 8'h22;
	localparam logic [7:0] MFR_2    = 8'h15;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEVICE  = 2'd0;
	localparam logic [1:0] CFG_TARGET  = 2'd1;
	localparam logic [1:0] CFG_COMMAND = 2'd2;

	// Emission steps of the back end, in message order
	localparam logic [STEP_W-1:0] STEP_SOX  = 5'd0;
	localparam logic [STEP_W-1:0] STEP_MFR0 = 5'd1;
	localparam logic [STEP_W-1:0] STEP_MFR1 = 5'd2;
	localparam logic [STEP_W-1:0] STEP_MFR2 = 5'd3;
	localparam logic [STEP_W-1:0] STEP_TGT  = 5'd4;
	localparam logic [STEP_W-1:0] STEP_DEV  = 5'd5;
	localparam logic [STEP_W-1:0] STEP_CMD  = 5'd6;
	localparam logic [STEP_W-1:0] STEP_ADR0 = 5'd7;
	localparam logic [STEP_W-1:0] STEP_ADR1 = 5'd8;
	localparam logic [STEP_W-1:0] STEP_ADR2 = 5'd9;
	localparam logic [STEP_W-1:0] STEP_ADR3 = 5'd10;
	localparam logic [STEP_W-1:0] STEP_LEN0 = 5'd11;
	localparam logic [STEP_W-1:0] STEP_LEN1 = 5'd12;
	localparam logic [STEP_W-1:0] STEP_LEN2 = 5'd13;
	localparam logic [STEP_W-1:0] STEP_LEN3 = 5'd14;
	localparam logic [STEP_W-1:0] STEP_SEP0 = 5'd15;
	localparam logic [STEP_W-1:0] STEP_SEP1 = 5'd16;
	localparam logic [STEP_W-1:0] STEP_REM  = 5'd17;
	localparam logic [STEP_W-1:0] STEP_CHK  = 5'd18;
	localparam logic [STEP_W-1:0] STEP_EOX  = 5'd19;

	typedef struct packed {
		logic [6:0] device_number;
		logic [7:0] target_code;
		logic [6:0] command_code;
	} cfg_t;

	// One classified word, as queued between front and back
	typedef struct packed {
		logic        first;
		logic        last;
		logic        two_septets;
		logic        rem_valid;
		logic [27:0] addr16;
		logic [27:0] len16;
		logic [6:0]  sep0;
		logic [6:0]  sep1;
		logic [6:0]  rem;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/core/spwf_front.sv
// Front end: accepts input words, repacks data bits into septets.
// Depends on spwf_pkg; feeds spwf_queue.
`default_nettype none

module spwf_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      data_byte,
	input  wire logic            first_of_message,
	input  wire logic            last_of_message,
	input  wire logic [31:0]     start_address,
	input  wire logic [31:0]     byte_count,
	input  wire logic            q_full,
	output logic                 push,
	output spwf_pkg::entry_t     push_entry
);
	import spwf_pkg::*;

	logic [5:0]  lb_q;
	logic [2:0]  lc_q;
	logic [5:0]  lb_eff;
	logic [2:0]  lc_eff;
	logic [13:0] acc;
	logic [2:0]  shamt;
	logic        two;
	logic [2:0]  new_lc;
	logic [5:0]  new_bits;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		// first word of a message drops any stale leftover
		lb_eff   = first_of_message ? 6'd0 : lb_q;
		lc_eff   = first_of_message ? 3'd0 : lc_q;
		acc      = {lb_eff, data_byte};
		shamt    = lc_eff + 3'd1;
		two      = (lc_eff == 3'd6);
		new_lc   = two ? 3'd0 : shamt;
		new_bits = acc[5:0] & 6'((7'd1 << new_lc) - 7'd1);

		push_entry.first       = first_of_message;
		push_entry.last        = last_of_message;
		push_entry.two_septets = two;
		push_entry.rem_valid   = (new_lc != 3'd0);
		push_entry.addr16      = start_address[31:4];
		push_entry.len16       = byte_count[31:4];
		push_entry.sep0        = 7'(acc >> shamt);
		push_entry.sep1        = acc[6:0];
		push_entry.rem         = 7'({1'b0, new_bits} << (3'd7 - new_lc));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q <= 6'd0;
			lc_q <= 3'd0;
		end else if (push) begin
			if (last_of_message) begin
				lb_q <= 6'd0;
				lc_q <= 3'd0;
			end else begin
				lb_q <= new_bits;
				lc_q <= new_lc;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/spwf_queue.sv
// Short FIFO of classified words between front and back end.
// Depends on spwf_pkg for the entry type.
`default_nettype none

module spwf_queue #(
	parameter int Depth = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire spwf_pkg::entry_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output spwf_pkg::entry_t      head,
	output logic                  not_empty
);
	import spwf_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	entry_t            mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/spwf_back.sv
// Back end: walks the emission steps of the queue head, keeps the checksum,
// drives the registered output word. Depends on spwf_pkg.
`default_nettype none

module spwf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire spwf_pkg::entry_t head,
	input  wire logic             head_valid,
	output logic                  pop,
	input  wire spwf_pkg::cfg_t   cfg,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  last_of_run,
	output logic                  end_of_message
);
	import spwf_pkg::*;

	logic              started_q;
	logic [STEP_W-1:0] step_q;
	logic [6:0]        sum_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              last_q;
	logic              eom_q;

	logic [STEP_W-1:0] cur_step;
	logic [STEP_W-1:0] nxt_step;
	logic              done;
	logic              adv;
	logic              counted;
	logic [7:0]        byte_d;
	logic [STEP_W-1:0] tail_step;

	assign cur_step  = started_q ? step_q : (head.first ? STEP_SOX : STEP_SEP0);
	assign adv       = head_valid && (!out_valid_q || out_ready);
	assign pop       = adv && done;
	assign tail_step = head.rem_valid ? STEP_REM : STEP_CHK;
	assign counted   = cur_step inside {[STEP_ADR0:STEP_REM]};

	always_comb begin
		done     = 1'b0;
		nxt_step = cur_step + 1'b1;
		case (cur_step)
			STEP_SEP0: begin
				if (head.two_septets) begin
					nxt_step = STEP_SEP1;
				end else if (head.last) begin
					nxt_step = tail_step;
				end else begin
					done = 1'b1;
				end
			end
			STEP_SEP1: begin
				if (head.last) begin
					nxt_step = tail_step;
				end else begin
					done = 1'b1;
				end
			end
			STEP_EOX: done = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		case (cur_step)
			STEP_SOX:  byte_d = SOX_BYTE;
			STEP_MFR0: byte_d = MFR_0;
			STEP_MFR1: byte_d = MFR_1;
			STEP_MFR2: byte_d = MFR_2;
			STEP_TGT:  byte_d = cfg.target_code;
			STEP_DEV:  byte_d = {1'b0, cfg.device_number};
			STEP_CMD:  byte_d = {1'b0, cfg.command_code};
			STEP_ADR0: byte_d = {1'b0, head.addr16[27:21]};
			STEP_ADR1: byte_d = {1'b0, head.addr16[20:14]};
			STEP_ADR2: byte_d = {1'b0, head.addr16[13:7]};
			STEP_ADR3: byte_d = {1'b0, head.addr16[6:0]};
			STEP_LEN0: byte_d = {1'b0, head.len16[27:21]};
			STEP_LEN1: byte_d = {1'b0, head.len16[20:14]};
			STEP_LEN2: byte_d = {1'b0, head.len16[13:7]};
			STEP_LEN3: byte_d = {1'b0, head.len16[6:0]};
			STEP_SEP0: byte_d = {1'b0, head.sep0};
			STEP_SEP1: byte_d = {1'b0, head.sep1};
			STEP_REM:  byte_d = {1'b0, head.rem};
			STEP_CHK:  byte_d = {1'b0, 7'd0 - sum_q};
			STEP_EOX:  byte_d = EOX_BYTE;
			default:   byte_d = EOX_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			step_q      <= STEP_SOX;
			sum_q       <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				started_q   <= !done;
				step_q      <= nxt_step;
				// header start and closing byte both restart the checksum
				if (cur_step == STEP_SOX || cur_step == STEP_EOX) begin
					sum_q <= 7'd0;
				end else if (counted) begin
					sum_q <= sum_q + byte_d[6:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= byte_d;
			last_q     <= done;
			eom_q      <= (cur_step == STEP_EOX);
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign last_of_run    = last_q;
	assign end_of_message = eom_q;

	a_eom_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_message |-> last_of_run && out_byte == EOX_BYTE)
		else $error("closing byte without end of run");

	a_started_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("step sequence running with empty queue");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cur_step == STEP_EOX |=> sum_q == 7'd0)
		else $error("checksum not cleared after closing byte");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && last_of_run)
		else $error("queue popped without last word of run");

endmodule

`default_nettype wire

>>> rtl/core/septet_packing_write_framer.sv
// Top level of the septet packing write framer: configuration registers,
// front end, word queue and back end. Depends on spwf_pkg.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, data_byte .. byte_count  in
//   output    out_valid/out_ready, out_byte, flags        out
//   config    cfg_write, cfg_index, cfg_data              in (write only)
//
// One output word leaves per cycle while the queue holds a word and out_ready
// does not stall it; an input word yields 1 to 19 of them: 1 or 2 for a
// plain data byte, 19 for a one-byte message with header, remainder, checksum
// and end byte. The back end's single output register sets that rate.
// Reset clears leftover bits, checksum, queue and output valid; no clearing pass.
// Input stalls only when the queue is full; output stalls hold the queue head.
`default_nettype none

module septet_packing_write_framer #(
	parameter int QueueDepth = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_of_message,
	input  wire logic        last_of_message,
	input  wire logic [31:0] start_address,
	input  wire logic [31:0] byte_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             end_of_message
);
	import spwf_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DEVICE:  cfg_q.device_number <= cfg_data[6:0];
				CFG_TARGET:  cfg_q.target_code   <= cfg_data;
				CFG_COMMAND: cfg_q.command_code  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	spwf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.start_address    (start_address),
		.byte_count       (byte_count),
		.q_full           (q_full),
		.push             (push),
		.push_entry       (push_entry)
	);

	spwf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.not_empty  (head_valid)
	);

	spwf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_valid     (head_valid),
		.pop            (pop),
		.cfg            (cfg_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.end_of_message (end_of_message)
	);

endmodule

`default_nettype wire

>>> tb/spwf_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the septet packing write framer: predicts the framed byte
// stream from the input and config ports and checks every output word.
// Depends on spwf_pkg for the framing bytes, register indexes and cfg_t.

module spwf_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_of_message,
	input  wire logic        last_of_message,
	input  wire logic [31:0] start_address,
	input  wire logic [31:0] byte_count,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  out_byte,
	input  wire logic        last_of_run,
	input  wire logic        end_of_message,
	output int               errors,
	output int               pending,
	output int               words_checked,
	output int               messages_closed
);
	import spwf_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       run_end;
		logic       closing;
	} framed_word_t;

	framed_word_t framed_due[$];
	framed_word_t want;
	cfg_t         regs;
	logic [5:0]   spare_bits;
	logic [2:0]   spare_count;
	logic [6:0]   septet_sum;
	int           fail_total = 0;
	int           checked_total = 0;
	int           closed_total = 0;

	function automatic void queue_word(logic [7:0] value, logic closing);
		framed_word_t w;
		w.value   = value;
		w.run_end = 1'b0;
		w.closing = closing;
		framed_due = {framed_due, w};
	endfunction

	// septets that enter the checksum
	function automatic void queue_septet(logic [6:0] septet);
		septet_sum = septet_sum + septet;
		queue_word({1'b0, septet}, 1'b0);
	endfunction

	function automatic void queue_groups(logic [27:0] v);
		queue_septet(v[27:21]);
		queue_septet(v[20:14]);
		queue_septet(v[13:7]);
		queue_septet(v[6:0]);
	endfunction

	function automatic void frame_payload_byte(logic [7:0] data, logic first, logic last,
		logic [31:0] addr, logic [31:0] count);
		logic [13:0]  acc;
		int           nbits;
		framed_word_t tail;
		if (first) begin
			spare_bits  = '0;
			spare_count = '0;
			septet_sum  = '0;
			queue_word(SOX_BYTE, 1'b0);
			queue_word(MFR_0, 1'b0);
			queue_word(MFR_1, 1'b0);
			queue_word(MFR_2, 1'b0);
			queue_word(regs.target_code, 1'b0);
			queue_word({1'b0, regs.device_number}, 1'b0);
			queue_word({1'b0, regs.command_code}, 1'b0);
			queue_groups(addr[31:4]);
			queue_groups(count[31:4]);
		end
		acc   = {spare_bits, data};
		nbits = int'(spare_count) + 8;
		while (nbits >= 7) begin
			nbits -= 7;
			queue_septet(7'(acc >> nbits));
		end
		spare_count = 3'(nbits);
		spare_bits  = 6'(acc & ((14'd1 << nbits) - 14'd1));
		if (last) begin
			// pad the remainder with zeros at the low end
			if (spare_count != 0)
				queue_septet(7'({1'b0, spare_bits} << (7 - spare_count)));
			queue_word({1'b0, 7'd0 - septet_sum}, 1'b0);
			queue_word(EOX_BYTE, 1'b1);
			spare_bits  = '0;
			spare_count = '0;
			septet_sum  = '0;
		end
		// mark the final word of this run
		tail = framed_due.pop_back();
		tail.run_end = 1'b1;
		framed_due = {framed_due, tail};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framed_due.delete();
			regs        = '0;
			spare_bits  = '0;
			spare_count = '0;
			septet_sum  = '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_DEVICE:  regs.device_number = cfg_data[6:0];
					CFG_TARGET:  regs.target_code   = cfg_data;
					CFG_COMMAND: regs.command_code  = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				frame_payload_byte(data_byte, first_of_message, last_of_message,
					start_address, byte_count);
			if (out_valid && out_ready) begin
				if (framed_due.size() == 0) begin
					$error("word with nothing expected: out_byte %h", out_byte);
					fail_total++;
				end else begin
					want = framed_due.pop_front();
					checked_total++;
					if (out_byte !== want.value) begin
						$error("out_byte: expected %h, got %h", want.value, out_byte);
						fail_total++;
					end
					if (last_of_run !== want.run_end) begin
						$error("last_of_run: expected %b, got %b", want.run_end, last_of_run);
						fail_total++;
					end
					if (end_of_message !== want.closing) begin
						$error("end_of_message: expected %b, got %b", want.closing,
							end_of_message);
						fail_total++;
					end
					if (want.closing)
						closed_total++;
				end
			end
		end
		errors          <= fail_total;
		pending         <= framed_due.size();
		words_checked   <= checked_total;
		messages_closed <= closed_total;
	end

endmodule

>>> tb/tb_septet_packing_write_framer.sv
`timescale 1ns / 100ps
// Top of the septet packing write framer testbench: clock, reset, config
// writes, message stimulus and receiver stalls. Depends on spwf_pkg, the
// framer RTL and spwf_frame_checker, which does all prediction and checking.

module tb_septet_packing_write_framer;
	import spwf_pkg::*;

	localparam int ITEM_TARGET   = 210;
	localparam int PHASES        = 4;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 30;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RUN_LIMIT_NS  = 2_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        first_of_message;
	logic        last_of_message;
	logic [31:0] start_address;
	logic [31:0] byte_count;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        end_of_message;

	int errors;
	int pending;
	int words_checked;
	int messages_closed;
	int words_sent = 0;
	int settings_used = 1;
	bit hold_req = 1'b0;
	bit calm = 1'b0;

	septet_packing_write_framer DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.start_address    (start_address),
		.byte_count       (byte_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.last_of_run      (last_of_run),
		.end_of_message   (end_of_message)
	);

	spwf_frame_checker frame_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.start_address    (start_address),
		.byte_count       (byte_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.last_of_run      (last_of_run),
		.end_of_message   (end_of_message),
		.errors           (errors),
		.pending          (pending),
		.words_checked    (words_checked),
		.messages_closed  (messages_closed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("septet_packing_write_framer verification failed");
		$finish;
	end

	// receiver: random stalls, a calm stretch, and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 17);
			end
		end
	end

	// mostly random values, with all-zero and all-one words mixed in
	function automatic logic [31:0] pick_word32();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic set_config(logic [6:0] dev, logic [7:0] tgt, logic [6:0] cmd);
		cfg_write <= 1'b1;
		cfg_index <= CFG_DEVICE;
		cfg_data  <= {1'b0, dev};
		@(posedge clk);
		cfg_index <= CFG_TARGET;
		cfg_data  <= tgt;
		@(posedge clk);
		cfg_index <= CFG_COMMAND;
		cfg_data  <= {1'b0, cmd};
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// leave valid high after the handshake; the next word or a gap decides
	task automatic send_word(logic [7:0] data, logic opens, logic closes,
		logic [31:0] addr, logic [31:0] count);
		in_valid         <= 1'b1;
		data_byte        <= data;
		first_of_message <= opens;
		last_of_message  <= closes;
		start_address    <= addr;
		byte_count       <= count;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (!calm) begin
			while ($urandom_range(99) < 17) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic send_message(int len, bit opens, bit closes);
		for (int i = 0; i < len; i++)
			send_word(8'(pick_word32()), opens && i == 0, closes && i == len - 1,
				pick_word32(), pick_word32());
	endtask

	// wait until every predicted word is out before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase;
		int quota;
		int roll;
		int waited;
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = CFG_DEVICE;
		cfg_data         = '0;
		in_valid         = 1'b0;
		data_byte        = '0;
		first_of_message = 1'b0;
		last_of_message  = 1'b0;
		start_address    = '0;
		byte_count       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes with no opening word, packed onto the reset state
		send_word(8'ha5, 1'b0, 1'b0, '1, '1);
		send_word(8'hff, 1'b0, 1'b1, '0, '0);
		drain();
		set_config(7'h7f, 8'hff, 7'h7f);
		// whole message in one word
		send_word(8'hff, 1'b1, 1'b1, '1, '1);
		// seven bytes leave no remainder septet
		for (int i = 0; i < 7; i++)
			send_word(i[0] ? 8'hff : 8'h00, i == 0, i == 6, 32'h0000000f, 32'h00000010);
		// abandon a message, then start over with leftover bits in flight
		send_word(8'h80, 1'b1, 1'b0, 32'h12345678, 32'h9abcdef0);
		send_word(8'h01, 1'b0, 1'b0, '0, '0);
		send_word(8'h7f, 1'b1, 1'b0, 32'hfffffff0, 32'h0000000f);
		send_word(8'hfe, 1'b0, 1'b0, '1, '0);
		send_word(8'h55, 1'b0, 1'b1, '0, '1);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				1: set_config(7'h00, 8'h00, 7'h00);
				2: set_config(7'h7f, 8'hff, 7'h7f);
				default: set_config(7'($urandom), 8'($urandom), 7'($urandom));
			endcase
			// fill the framer while the receiver is held off
			if (phase == 1)
				hold_req = 1'b1;
			calm  = (phase == 2);
			quota = words_sent + ITEM_TARGET / PHASES;
			while (words_sent < quota) begin
				roll = $urandom_range(99);
				if (roll < 8)
					send_message($urandom_range(1, 3), 1'b0, 1'($urandom_range(1)));
				else if (roll < 15)
					send_message($urandom_range(1, 5), 1'b1, 1'b0);
				else if (roll < 22)
					send_message($urandom_range(15, 40), 1'b1, 1'b1);
				else
					send_message($urandom_range(1, 10), 1'b1, 1'b1);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending != 0)
			$error("%0d expected words never came out", pending);
		$display("Sent %0d payload bytes across %0d register settings, with a %0d-cycle stall.",
			words_sent, settings_used, HOLD_CYCLES);
		$display("Checked %0d framed words and %0d closed messages.",
			words_checked, messages_closed);
		if (errors == 0 && pending == 0)
			$display("septet_packing_write_framer verification clean");
		else
			$display("septet_packing_write_framer verification failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/spwf_pkg.sv
rtl/core/spwf_front.sv
rtl/core/spwf_queue.sv
rtl/core/spwf_back.sv
rtl/core/septet_packing_write_framer.sv
tb/spwf_frame_checker.sv
tb/tb_septet_packing_write_framer.sv
